// ===== rtl/core/fulf_pkg.sv =====
// Package for the first unique letter finder.
// Holds the input and result word types, the letter mark codes and the memory entry.
// It has no dependencies.
package fulf_pkg;

  localparam int unsigned POS_W = 16;
  localparam logic [7:0] LetterBase = 8'h61;

  typedef enum logic [1:0] {
    MARK_UNSEEN   = 2'd0,
    MARK_ONCE     = 2'd1,
    MARK_REPEATED = 2'd2
  } mark_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] first_position;
    logic             input_error;
  } out_t;

  typedef struct packed {
    mark_e            mark;
    logic [POS_W-1:0] pos;
  } entry_t;

endpackage

// ===== rtl/core/first_unique_letter_finder.sv =====
// Top level of the first unique letter finder.
// Depends on fulf_pkg for the word types, the mark codes and the memory entry.
//
// Bytes of a string are taken one per cycle. Each letter has an entry in a
// small synchronous memory with a registered read port, updated by read,
// modify and write back, with forwarding when the same letter arrives on
// consecutive bytes. After the last byte the block stops taking words while it
// drains and scans, and longer while an earlier result word still waits
// to be taken: a drain state for the last write back, a scan state in which
// the single read port reads every entry for the smallest position of a letter
// seen once, and a final state that loads the result register.
// Bytes that are not letters, and bytes past MAX_LENGTH, set input_error.
module first_unique_letter_finder #(
  parameter int unsigned ALPHABET_SIZE = 26,
  parameter int unsigned MAX_LENGTH    = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fulf_pkg::in_t     in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fulf_pkg::out_t    out_data_o
);

  localparam int unsigned IDX_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_LENGTH + 1);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_SCAN,
    ST_FIN
  } state_e;

  state_e                     state_q;
  logic [ALPHABET_SIZE-1:0]   valid_q;
  logic [CNT_W-1:0]           count_q;
  logic                       error_q;
  logic                       err_hold_q;
  logic                       s1_valid_q;
  logic [IDX_W-1:0]           s1_idx_q;
  logic [fulf_pkg::POS_W-1:0] s1_pos_q;
  logic                       fwd_q;
  fulf_pkg::entry_t           fwd_data_q;
  logic [IDX_W-1:0]           rd_idx_q;
  logic                       cmp_valid_q;
  logic [IDX_W-1:0]           cmp_idx_q;
  logic                       found_q;
  logic [fulf_pkg::POS_W-1:0] best_q;
  logic                       out_valid_q;
  fulf_pkg::out_t             out_data_q;

  fulf_pkg::entry_t mem_q [ALPHABET_SIZE];
  fulf_pkg::entry_t rdata_q;

  logic                       accept;
  logic [7:0]                 diff;
  logic                       is_letter;
  logic                       overflow;
  logic [IDX_W-1:0]           in_idx;
  logic                       rd_en;
  logic [IDX_W-1:0]           raddr;
  fulf_pkg::entry_t           cur;
  logic                       cur_valid;
  fulf_pkg::entry_t           wdata;
  logic                       found_d;
  logic [fulf_pkg::POS_W-1:0] best_d;
  logic                       out_load;

  assign in_ready_o  = (state_q == ST_LOAD);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign diff      = in_data_i.char_byte - fulf_pkg::LetterBase;
  assign is_letter = (in_data_i.char_byte >= fulf_pkg::LetterBase) &&
                     ({24'd0, diff} < ALPHABET_SIZE);
  assign overflow  = (count_q >= CNT_W'(MAX_LENGTH));
  assign in_idx    = diff[IDX_W-1:0];

  assign rd_en = accept || (state_q == ST_SCAN);
  assign raddr = (state_q == ST_SCAN) ? rd_idx_q : in_idx;

  always_comb begin
    cur       = fwd_q ? fwd_data_q : rdata_q;
    cur_valid = fwd_q || valid_q[s1_idx_q];
    if (cur_valid) begin
      wdata.mark = fulf_pkg::MARK_REPEATED;
      wdata.pos  = cur.pos;
    end else begin
      wdata.mark = fulf_pkg::MARK_ONCE;
      wdata.pos  = s1_pos_q;
    end
  end

  always_comb begin
    found_d = found_q;
    best_d  = best_q;
    if (cmp_valid_q && valid_q[cmp_idx_q] && (rdata_q.mark == fulf_pkg::MARK_ONCE) &&
        (!found_q || (rdata_q.pos < best_q))) begin
      found_d = 1'b1;
      best_d  = rdata_q.pos;
    end
  end

  assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      mem_q[s1_idx_q] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
    fwd_data_q <= wdata;
    s1_idx_q   <= in_idx;
    s1_pos_q   <= fulf_pkg::POS_W'(count_q);
    cmp_idx_q  <= rd_idx_q;
    best_q     <= best_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      valid_q     <= '0;
      count_q     <= '0;
      error_q     <= 1'b0;
      err_hold_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      rd_idx_q    <= '0;
      cmp_valid_q <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      s1_valid_q  <= accept && is_letter && !overflow;
      fwd_q       <= accept && s1_valid_q && (s1_idx_q == in_idx);
      cmp_valid_q <= (state_q == ST_SCAN);
      found_q     <= (state_q == ST_DRAIN) ? 1'b0 : found_d;
      if (s1_valid_q) begin
        valid_q[s1_idx_q] <= 1'b1;
      end
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_LOAD: begin
          if (accept) begin
            if (in_data_i.last_char) begin
              err_hold_q <= error_q || overflow || !is_letter;
              error_q    <= 1'b0;
              count_q    <= '0;
              state_q    <= ST_DRAIN;
            end else begin
              error_q <= error_q || overflow || !is_letter;
              if (!overflow) begin
                count_q <= count_q + CNT_W'(1);
              end
            end
          end
        end
        ST_DRAIN: begin
          rd_idx_q <= '0;
          state_q  <= ST_SCAN;
        end
        ST_SCAN: begin
          if (rd_idx_q == IDX_W'(ALPHABET_SIZE - 1)) begin
            state_q <= ST_FIN;
          end else begin
            rd_idx_q <= rd_idx_q + IDX_W'(1);
          end
        end
        ST_FIN: begin
          if (out_load) begin
            out_valid_q                <= 1'b1;
            out_data_q.found           <= found_d;
            out_data_q.first_position  <= found_d ? best_d : '0;
            out_data_q.input_error     <= err_hold_q;
            valid_q                    <= '0;
            state_q                    <= ST_LOAD;
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/fulf_checker.sv =====
// Port-level checker for the first unique letter finder, with its bind statement.
// Depends on fulf_pkg for the word types and on first_unique_letter_finder.
module fulf_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input fulf_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input fulf_pkg::out_t out_data_o
);

  // A waiting result word holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // A not-found result carries position zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |-> out_data_o.first_position == '0)
    else $error("not-found result with nonzero position");

  // After the last byte of a string the block pauses for its scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last_char |=> !in_ready_o ##1 !in_ready_o)
    else $error("input taken during the scan");

  // A taken last byte is not followed at once by a new result word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last_char |=> !$rose(out_valid_o))
    else $error("result word appeared too early");

endmodule

bind first_unique_letter_finder fulf_checker u_fulf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== tb/sv/tb_first_unique_letter_finder.sv =====
// Testbench for the first unique letter finder: drives strings of bytes with random gaps on
// both sides and checks every answer against a scoreboard that tracks letter marks itself.
// Depends on fulf_pkg and the first_unique_letter_finder top level.
module tb_first_unique_letter_finder;

  localparam int unsigned Alpha      = 26;
  localparam int unsigned MaxLen     = 65536;
  localparam int unsigned StallLimit = 2000;

  class unique_letter_board;
    fulf_pkg::mark_e            marks[Alpha];
    logic [fulf_pkg::POS_W-1:0] first_pos[Alpha];
    logic [16:0]                pos_count = '0;
    logic                       err_seen = 1'b0;
    fulf_pkg::out_t             answers_due[$];
    int                         fail_count = 0;

    function void clear_string();
      foreach (marks[i]) marks[i] = fulf_pkg::MARK_UNSEEN;
      pos_count = '0;
      err_seen  = 1'b0;
    endfunction

    function void take_byte(fulf_pkg::in_t w);
      int unsigned                idx;
      logic                       found;
      logic [fulf_pkg::POS_W-1:0] best;
      fulf_pkg::out_t             ans;
      if (pos_count >= MaxLen) begin
        err_seen = 1'b1;
      end else begin
        if (w.char_byte < fulf_pkg::LetterBase ||
            w.char_byte >= fulf_pkg::LetterBase + Alpha) begin
          err_seen = 1'b1;
        end else begin
          idx = w.char_byte - fulf_pkg::LetterBase;
          if (marks[idx] == fulf_pkg::MARK_UNSEEN) begin
            marks[idx]     = fulf_pkg::MARK_ONCE;
            first_pos[idx] = pos_count[fulf_pkg::POS_W-1:0];
          end else begin
            marks[idx] = fulf_pkg::MARK_REPEATED;
          end
        end
        pos_count++;
      end
      if (!w.last_char) return;
      found = 1'b0;
      best  = '0;
      for (int i = 0; i < Alpha; i++) begin
        if (marks[i] == fulf_pkg::MARK_ONCE && (!found || first_pos[i] < best)) begin
          best  = first_pos[i];
          found = 1'b1;
        end
      end
      ans.found          = found;
      ans.first_position = found ? best : '0;
      ans.input_error    = err_seen;
      answers_due.push_back(ans);
      clear_string();
    endfunction

    function void check_answer(fulf_pkg::out_t got);
      fulf_pkg::out_t want;
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected word found=%0b first_position=%0d input_error=%0b",
                 $time, got.found, got.first_position, got.input_error);
        fail_count++;
        return;
      end
      want = answers_due.pop_front();
      if (got.found !== want.found) begin
        $display("%0t: found expected %0b, got %0b", $time, want.found, got.found);
        fail_count++;
      end
      if (got.first_position !== want.first_position) begin
        $display("%0t: first_position expected %0d, got %0d", $time,
                 want.first_position, got.first_position);
        fail_count++;
      end
      if (got.input_error !== want.input_error) begin
        $display("%0t: input_error expected %0b, got %0b", $time,
                 want.input_error, got.input_error);
        fail_count++;
      end
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid;
  logic           in_ready;
  fulf_pkg::in_t  in_word;
  logic           out_valid;
  logic           out_ready;
  fulf_pkg::out_t out_word;

  unique_letter_board board = new;
  bit                 idle_en = 1'b1;
  int                 sent_words = 0;
  int unsigned        stall_cycles = 0;

  first_unique_letter_finder #(
    .ALPHABET_SIZE(Alpha),
    .MAX_LENGTH   (MaxLen)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_word)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int pick_gap();
    int r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(input fulf_pkg::in_t w);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_word  = w;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    board.take_byte(w);
    sent_words++;
    @(negedge clk_i);
  endtask

  task automatic send_string(input logic [7:0] s[$]);
    fulf_pkg::in_t w;
    for (int i = 0; i < s.size(); i++) begin
      w.char_byte = s[i];
      w.last_char = (i == s.size() - 1);
      send_word(w);
    end
  endtask

  task automatic send_random_string();
    logic [7:0] s[$];
    int         r;
    int         len;
    int         span;
    int         offset;
    bit         noise;
    r = $urandom_range(0, 99);
    if (r < 80) len = $urandom_range(1, 10);
    else if (r < 97) len = $urandom_range(11, 40);
    else len = $urandom_range(41, 200);
    span   = $urandom_range(1, Alpha);
    offset = $urandom_range(0, Alpha - span);
    noise  = ($urandom_range(0, 99) < 10);
    for (int i = 0; i < len; i++) begin
      if (noise || $urandom_range(0, 99) < 3) begin
        s.push_back(8'($urandom_range(0, 255)));
      end else begin
        s.push_back(fulf_pkg::LetterBase + 8'(offset + $urandom_range(0, span - 1)));
      end
    end
    send_string(s);
  endtask

  task automatic drain_answers();
    in_valid = 1'b0;
    while (board.answers_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_random_phase(input int words);
    int target;
    target = sent_words + words;
    while (sent_words < target) send_random_string();
  endtask

  initial begin
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    board.clear_string();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_string({8'h61});
    send_string({8'h61, 8'h61});
    send_string({8'h61, 8'h61, 8'h61, 8'h62});
    send_string({8'h00});
    send_string({8'h60, 8'h7a, 8'h7b, 8'hff});
    send_string({8'h7a, 8'h7a, 8'h79, 8'h78, 8'h61});
    send_string({8'h78, 8'h79, 8'h79, 8'h78});

    send_random_phase(300);
    drain_answers();
    idle_en = 1'b0;
    send_random_phase(200);
    drain_answers();
    idle_en = 1'b1;
    send_random_phase(250);

    drain_answers();
    repeat (Alpha + 12) @(negedge clk_i);
    if (board.fail_count == 0 && board.answers_due.size() == 0) begin
      $display("tb_first_unique_letter_finder: PASS");
    end else begin
      $display("tb_first_unique_letter_finder: FAIL");
    end
    $finish;
  end

  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = pick_gap();
      if (gap != 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready = 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) board.check_answer(out_word);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles == StallLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, StallLimit);
        $display("tb_first_unique_letter_finder: FAIL");
        $finish;
      end
    end
  end

endmodule
